[sv/ades_pkg.sv]
// ----------------------------------------------------------------------------
// ades_pkg
// shared widths, register indexes and reset values of the speed estimator
// ----------------------------------------------------------------------------
package ades_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 21;
  localparam int unsigned TIMER_BITS_DEF = 16;

  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned FREQ_W     = 27;
  localparam int unsigned DEADBAND_W = 21;
  localparam int unsigned MAX_W      = 40;
  localparam int unsigned SPEED_W    = MAX_W + 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMER_PERIOD    = 2'd0,
    REG_TIMER_FREQUENCY = 2'd1,
    REG_MIN_DELTA       = 2'd2,
    REG_MAX_SPEED       = 2'd3
  } cfg_reg_e;

  localparam logic [PERIOD_W-1:0]   RST_PERIOD    = 16'd65535;
  localparam logic [FREQ_W-1:0]     RST_FREQUENCY = 27'd1000000;
  localparam logic [DEADBAND_W-1:0] RST_MIN_DELTA = 21'd10;
  localparam logic [MAX_W-1:0]      RST_MAX_SPEED = 40'd209715200;

endpackage

[sv/ades_if.sv]
// ----------------------------------------------------------------------------
// ades_if
// valid/ready channels of the speed estimator: samples, results, config
// ----------------------------------------------------------------------------
interface ades_in_if #(
  parameter int unsigned ANGLE_BITS = ades_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TIMER_BITS = ades_pkg::TIMER_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle_sample;
  logic [TIMER_BITS-1:0] timer_count;

  modport source (output valid, output angle_sample, output timer_count, input ready);
  modport sink   (input valid, input angle_sample, input timer_count, output ready);
endinterface

interface ades_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ades_pkg::SPEED_W-1:0]  speed;
  logic                                 standing_still;
  logic                                 saturated;

  modport source (output valid, output speed, output standing_still, output saturated,
                  input ready);
  modport sink   (input valid, input speed, input standing_still, input saturated,
                  output ready);
endinterface

interface ades_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ades_pkg::CFG_IDX_W-1:0]    index;
  logic [ades_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/angle_delta_speed_estimator.sv]
// ----------------------------------------------------------------------------
// angle_delta_speed_estimator
// speed from successive absolute angle samples and timer counts
// ----------------------------------------------------------------------------
// Each accepted word (angle sample plus timer count) is compared with the
// previous one; the signed angle change times timer_frequency is divided by
// the tick difference and clamped to +-max_speed. The first word after reset
// only loads the history and gives no result; the block is ready again on the
// next cycle. A normal word passes through the prepare, check, divide, clamp
// and output steps before the block is ready again; the restoring divider in
// the divide step produces one quotient bit per cycle over the ANGLE_BITS + 27
// bit product. Deadband, zero-frequency and zero-tick words skip divide and
// clamp. A finished result sits in the output register while the next word
// is taken; a word waits in its last step for as long as the output register
// still holds an unaccepted result. Configuration writes are taken at any time
// and must only be issued while idle.
// ----------------------------------------------------------------------------
module angle_delta_speed_estimator #(
  parameter int unsigned ANGLE_BITS = ades_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TIMER_BITS = ades_pkg::TIMER_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ades_cfg_if.sink   cfg_i,
  ades_in_if.sink    in_i,
  ades_out_if.source out_o
);

  localparam int unsigned PER_W = (TIMER_BITS < ades_pkg::PERIOD_W) ?
                                  TIMER_BITS : ades_pkg::PERIOD_W;
  localparam int unsigned MIN_W = (ANGLE_BITS < ades_pkg::DEADBAND_W) ?
                                  ANGLE_BITS : ades_pkg::DEADBAND_W;
  localparam int unsigned NUM_W = ANGLE_BITS + ades_pkg::FREQ_W;
  localparam int unsigned DT_W  = TIMER_BITS + 2;
  localparam int unsigned CMP_W = (NUM_W > ades_pkg::MAX_W) ? NUM_W : ades_pkg::MAX_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_CHECK = 6'b000100,
    S_DIV   = 6'b001000,
    S_CLAMP = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  // configuration
  logic [PER_W-1:0]                 period_q;
  logic [ades_pkg::FREQ_W-1:0]      freq_q;
  logic [MIN_W-1:0]                 min_q;
  logic [ades_pkg::MAX_W-1:0]       max_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= ades_pkg::RST_PERIOD[PER_W-1:0];
      freq_q   <= ades_pkg::RST_FREQUENCY;
      min_q    <= ades_pkg::RST_MIN_DELTA[MIN_W-1:0];
      max_q    <= ades_pkg::RST_MAX_SPEED;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (ades_pkg::cfg_reg_e'(cfg_i.index))
        ades_pkg::REG_TIMER_PERIOD:    period_q <= cfg_i.data[PER_W-1:0];
        ades_pkg::REG_TIMER_FREQUENCY: freq_q   <= cfg_i.data[ades_pkg::FREQ_W-1:0];
        ades_pkg::REG_MIN_DELTA:       min_q    <= cfg_i.data[MIN_W-1:0];
        ades_pkg::REG_MAX_SPEED:       max_q    <= cfg_i.data[ades_pkg::MAX_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  state_e                      state_q, state_d;
  logic                        have_q, have_d;
  logic [ANGLE_BITS-1:0]       last_angle_q, last_angle_d;
  logic [TIMER_BITS-1:0]       last_count_q, last_count_d;
  logic [ANGLE_BITS-1:0]       du_q, du_d;
  logic [TIMER_BITS-1:0]       cnt_q, cnt_d;
  logic [TIMER_BITS-1:0]       pc_q, pc_d;
  logic [ANGLE_BITS-1:0]       mag_q, mag_d;
  logic                        neg_q, neg_d;
  logic [TIMER_BITS-1:0]       dt_q, dt_d;
  logic                        dt_pos_q, dt_pos_d;
  logic [NUM_W-1:0]            quo_q, quo_d;
  logic [TIMER_BITS-1:0]       rem_q, rem_d;
  logic [CNT_W-1:0]            bit_cnt_q, bit_cnt_d;
  logic [ades_pkg::MAX_W-1:0]  res_mag_q, res_mag_d;
  logic                        res_still_q, res_still_d;
  logic                        res_sat_q, res_sat_d;

  // output register
  logic                                out_valid_q, out_valid_d;
  logic [ades_pkg::SPEED_W-1:0]        speed_q, speed_d;
  logic                                still_q, still_d;
  logic                                sat_q, sat_d;

  logic                        in_acc;
  logic                        out_load;
  logic [DT_W-1:0]             dt_wrap;
  logic [NUM_W-1:0]            prod;
  logic [TIMER_BITS:0]         trial;
  logic                        take;
  logic [CMP_W-1:0]            quo_ext;
  logic [CMP_W-1:0]            max_ext;
  logic [ades_pkg::SPEED_W-1:0] mag_ext;

  function automatic logic [ades_pkg::SPEED_W-1:0] res_neg_sel(
    input logic                         neg,
    input logic [ades_pkg::SPEED_W-1:0] m
  );
    res_neg_sel = neg ? (~m + 1'b1) : m;
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  assign dt_wrap = DT_W'(period_q) - DT_W'(pc_q) + DT_W'(cnt_q) + DT_W'(1);
  assign prod    = NUM_W'(mag_q) * NUM_W'(freq_q);
  assign trial   = {rem_q, quo_q[NUM_W-1]};
  assign take    = (trial >= {1'b0, dt_q});
  assign quo_ext = CMP_W'(quo_q);
  assign max_ext = CMP_W'(max_q);
  assign mag_ext = {1'b0, res_mag_q};

  always_comb begin
    state_d      = state_q;
    have_d       = have_q;
    last_angle_d = last_angle_q;
    last_count_d = last_count_q;
    du_d         = du_q;
    cnt_d        = cnt_q;
    pc_d         = pc_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    dt_d         = dt_q;
    dt_pos_d     = dt_pos_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    bit_cnt_d    = bit_cnt_q;
    res_mag_d    = res_mag_q;
    res_still_d  = res_still_q;
    res_sat_d    = res_sat_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          last_angle_d = in_i.angle_sample;
          last_count_d = in_i.timer_count;
          have_d       = 1'b1;
          du_d         = in_i.angle_sample - last_angle_q;
          cnt_d        = in_i.timer_count;
          pc_d         = last_count_q;
          if (have_q) begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        neg_d = du_q[ANGLE_BITS-1];
        mag_d = du_q[ANGLE_BITS-1] ? (~du_q + 1'b1) : du_q;
        if (cnt_q >= pc_q) begin
          dt_d     = cnt_q - pc_q;
          dt_pos_d = (cnt_q != pc_q);
        end else begin
          dt_d     = dt_wrap[TIMER_BITS-1:0];
          dt_pos_d = !dt_wrap[DT_W-1] && (dt_wrap != '0);
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        res_still_d = 1'b0;
        res_sat_d   = 1'b0;
        res_mag_d   = '0;
        if (freq_q == '0) begin
          state_d = S_OUT;
        end else if (mag_q < ANGLE_BITS'(min_q)) begin
          res_still_d = 1'b1;
          state_d     = S_OUT;
        end else if (!dt_pos_q) begin
          res_sat_d = 1'b1;
          res_mag_d = (mag_q != '0) ? max_q : '0;
          state_d   = S_OUT;
        end else begin
          quo_d     = prod;
          rem_d     = '0;
          bit_cnt_d = CNT_W'(NUM_W - 1);
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = take ? TIMER_BITS'(trial - {1'b0, dt_q}) : trial[TIMER_BITS-1:0];
        quo_d = {quo_q[NUM_W-2:0], take};
        if (bit_cnt_q == '0) begin
          state_d = S_CLAMP;
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
        end
      end
      S_CLAMP: begin
        if (quo_ext > max_ext) begin
          res_mag_d = max_q;
          res_sat_d = 1'b1;
        end else begin
          res_mag_d = quo_ext[ades_pkg::MAX_W-1:0];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    speed_d     = speed_q;
    still_d     = still_q;
    sat_d       = sat_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      speed_d     = res_neg_sel(neg_q, mag_ext);
      still_d     = res_still_q;
      sat_d       = res_sat_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      have_q       <= 1'b0;
      last_angle_q <= '0;
      last_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      have_q       <= have_d;
      last_angle_q <= last_angle_d;
      last_count_q <= last_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    du_q        <= du_d;
    cnt_q       <= cnt_d;
    pc_q        <= pc_d;
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    dt_q        <= dt_d;
    dt_pos_q    <= dt_pos_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    bit_cnt_q   <= bit_cnt_d;
    res_mag_q   <= res_mag_d;
    res_still_q <= res_still_d;
    res_sat_q   <= res_sat_d;
    speed_q     <= speed_d;
    still_q     <= still_d;
    sat_q       <= sat_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.speed          = $signed(speed_q);
  assign out_o.standing_still = still_q;
  assign out_o.saturated      = sat_q;

  // checks
  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !have_q |=> state_q == S_IDLE)
    else $error("first word must not start a computation");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && bit_cnt_q == '0 |=> state_q == S_CLAMP)
    else $error("divider did not finish after its last bit");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < dt_q)
    else $error("partial remainder not below divisor");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result loaded outside of the output step");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(still_q && sat_q))
    else $error("standing still and saturated both set");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the angle delta speed estimator
// ----------------------------------------------------------------------------
// Drives angle/timer words over the input channel and register writes over the
// config channel while the block is idle. Every accepted word runs through a
// local speed predictor; each result word is checked field by field against
// the oldest prediction. Covers reset settings, register extremes, random
// settings with mostly plausible motion, and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned AW = ades_pkg::ANGLE_BITS_DEF;
  localparam int unsigned TW = ades_pkg::TIMER_BITS_DEF;
  localparam int unsigned PW = ades_pkg::PERIOD_W;
  localparam int unsigned FW = ades_pkg::FREQ_W;
  localparam int unsigned DW = ades_pkg::DEADBAND_W;
  localparam int unsigned MW = ades_pkg::MAX_W;
  localparam int unsigned SW = ades_pkg::SPEED_W;
  localparam int unsigned CW = ades_pkg::CFG_DATA_W;
  localparam logic [AW-1:0] HALF_TURN = AW'(1) << (AW - 1);
  localparam logic [FW-1:0] FREQ_TOP = '1;
  localparam logic [MW-1:0] MAX_TOP = '1;
  localparam logic [DW-1:0] DEAD_TOP = DW'(1) << (AW - 1);
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned LIMIT_CYCLES = 1000000;

  typedef struct {
    logic signed [SW-1:0] speed;
    logic standing_still;
    logic saturated;
  } speed_word_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE} rx_mode_e;
  typedef enum int {MOVE_SMALL, MOVE_LARGE, MOVE_HALF, MOVE_NONE, MOVE_NEAR_DEAD,
                    MOVE_JUMP} motion_e;

  logic clk_i;
  logic rst_n;

  ades_in_if  in_if ();
  ades_out_if out_if ();
  ades_cfg_if cfg_if ();

  angle_delta_speed_estimator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if.sink),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // predictor copy of registers and history
  logic [PW-1:0]   cfg_period   = ades_pkg::RST_PERIOD;
  logic [FW-1:0]   cfg_freq     = ades_pkg::RST_FREQUENCY;
  logic [DW-1:0]   cfg_deadband = ades_pkg::RST_MIN_DELTA;
  logic [MW-1:0]   cfg_max      = ades_pkg::RST_MAX_SPEED;
  logic [AW-1:0]   prev_angle   = '0;
  logic [TW-1:0]   prev_count   = '0;
  bit              have_prev    = 1'b0;

  speed_word_t pending_speeds[$];

  logic [AW-1:0] sent_angle = '0;
  logic [TW-1:0] sent_count = '0;
  int burst_left = 0;
  int hold_cycles = 0;
  int errors = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_writes = 0;
  int unsigned cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d speed words pending", cycles,
             pending_speeds.size());
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic compute_speed(input logic [AW-1:0] angle, input logic [TW-1:0] count);
    logic [AW-1:0] diff;
    longint unsigned mag;
    longint unsigned quot;
    longint ticks;
    bit neg;
    bit had;
    speed_word_t w;
    had = have_prev;
    diff = angle - prev_angle;
    if (count >= prev_count)
      ticks = longint'(count) - longint'(prev_count);
    else
      ticks = longint'(cfg_period) - longint'(prev_count) + longint'(count) + 1;
    prev_angle = angle;
    prev_count = count;
    have_prev = 1'b1;
    if (!had) return;
    neg = diff[AW-1];
    mag = neg ? (64'd1 << AW) - 64'(diff) : 64'(diff);
    w.speed = '0;
    w.standing_still = 1'b0;
    w.saturated = 1'b0;
    if (cfg_freq != 0) begin
      if (mag < cfg_deadband) begin
        w.standing_still = 1'b1;
      end else if (ticks <= 0) begin
        w.saturated = 1'b1;
        if (mag != 0) w.speed = SW'(neg ? -longint'(cfg_max) : longint'(cfg_max));
      end else begin
        quot = (mag * 64'(cfg_freq)) / 64'(ticks);
        if (quot > cfg_max) begin
          quot = 64'(cfg_max);
          w.saturated = 1'b1;
        end
        w.speed = SW'(neg ? -longint'(quot) : longint'(quot));
      end
    end
    pending_speeds.push_back(w);
  endtask

  // result checker
  always @(posedge clk_i) begin
    speed_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_results++;
      if (pending_speeds.size() == 0) begin
        report_mismatch("result word with nothing pending", longint'(out_if.speed), 0);
      end else begin
        want = pending_speeds.pop_front();
        if (out_if.speed !== want.speed)
          report_mismatch("speed", longint'(out_if.speed), longint'(want.speed));
        if (out_if.standing_still !== want.standing_still)
          report_mismatch("standing_still", longint'(out_if.standing_still),
                          longint'(want.standing_still));
        if (out_if.saturated !== want.saturated)
          report_mismatch("saturated", longint'(out_if.saturated),
                          longint'(want.saturated));
      end
    end
  end

  // output stall pattern plus long hold-off on request
  initial begin
    rx_mode_e mode;
    int mode_left;
    mode = RX_ALWAYS;
    mode_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS: out_if.ready <= 1'b1;
          RX_RANDOM: out_if.ready <= 1'($urandom_range(0, 1));
          default:   out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(input logic [AW-1:0] angle, input logic [TW-1:0] count);
    in_if.valid <= 1'b1;
    in_if.angle_sample <= angle;
    in_if.timer_count <= count;
    do @(posedge clk_i); while (!in_if.ready);
    compute_speed(angle, count);
    sent_angle = angle;
    sent_count = count;
    n_samples++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(10, 70)) @(negedge clk_i);
      else
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(40, 120))
                                               : int'($urandom_range(0, 12));
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_speeds.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input ades_pkg::cfg_reg_e idx, input logic [CW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      ades_pkg::REG_TIMER_PERIOD:    cfg_period = data[PW-1:0];
      ades_pkg::REG_TIMER_FREQUENCY: cfg_freq = data[FW-1:0];
      ades_pkg::REG_MIN_DELTA:       cfg_deadband = data[DW-1:0];
      ades_pkg::REG_MAX_SPEED:       cfg_max = data[MW-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [PW-1:0] period, input logic [FW-1:0] freq,
                            input logic [DW-1:0] dead, input logic [MW-1:0] lim);
    wait_idle();
    write_reg(ades_pkg::REG_TIMER_PERIOD, CW'(period));
    write_reg(ades_pkg::REG_TIMER_FREQUENCY, CW'(freq));
    write_reg(ades_pkg::REG_MIN_DELTA, CW'(dead));
    write_reg(ades_pkg::REG_MAX_SPEED, CW'(lim));
  endtask

  task automatic send_random_samples(input int n);
    motion_e motion;
    int unsigned r;
    int unsigned dmag;
    int unsigned ticks;
    int unsigned top;
    logic [AW-1:0] angle;
    logic [TW-1:0] count;
    repeat (n) begin
      r = $urandom_range(0, 15);
      if (r <= 6) motion = MOVE_SMALL;
      else if (r <= 9) motion = MOVE_LARGE;
      else if (r == 10) motion = MOVE_HALF;
      else if (r == 11) motion = MOVE_NONE;
      else if (r <= 13) motion = MOVE_NEAR_DEAD;
      else motion = MOVE_JUMP;
      case (motion)
        MOVE_SMALL:     dmag = $urandom_range(0, 4095);
        MOVE_LARGE:     dmag = $urandom_range(0, (1 << (AW - 1)) - 1);
        MOVE_HALF:      dmag = 1 << (AW - 1);
        MOVE_NONE:      dmag = 0;
        MOVE_NEAR_DEAD: dmag = (cfg_deadband == 0) ? $urandom_range(0, 1)
                               : 32'(cfg_deadband) + $urandom_range(0, 2) - 1;
        default:        dmag = 0;
      endcase
      if (motion == MOVE_JUMP)
        angle = AW'($urandom_range(0, (1 << AW) - 1));
      else if ($urandom_range(0, 1) == 1)
        angle = sent_angle - AW'(dmag);
      else
        angle = sent_angle + AW'(dmag);
      r = $urandom_range(0, 15);
      if (r == 0) begin
        count = sent_count;
      end else if (r == 1) begin
        count = TW'($urandom_range(0, (1 << TW) - 1));
      end else begin
        top = (r < 8 && cfg_period > 50) ? 50 : 32'(cfg_period);
        ticks = $urandom_range(1, top);
        count = TW'((int'(sent_count) + ticks) % (int'(cfg_period) + 1));
      end
      send_sample(angle, count);
    end
  endtask

  task automatic test_reset_defaults();
    send_sample(21'd1000, 16'd100);
    send_sample(21'd1000, 16'd200);
    send_sample(21'd1009, 16'd300);
    send_sample(21'd1100, 16'd400);
    send_sample(21'd600, 16'd1400);
    send_sample(21'd600 + HALF_TURN, 16'd1500);
    send_sample(21'd650 + HALF_TURN, 16'd1500);
    send_sample(21'd850 + HALF_TURN, 16'd20);
    send_sample('1, '1);
    send_sample('0, '1);
    send_sample(21'd40000, 16'd0);
  endtask

  task automatic test_register_extremes();
    set_config(ades_pkg::RST_PERIOD, '0, ades_pkg::RST_MIN_DELTA, ades_pkg::RST_MAX_SPEED);
    send_sample(21'd5000, 16'd1000);
    send_sample(21'd9000, 16'd1100);
    set_config(ades_pkg::RST_PERIOD, 27'd1, '0, MAX_TOP);
    send_sample(21'd9000, 16'd1100);
    send_sample(21'd9000, 16'd1200);
    send_sample(21'd9001, 16'd1300);
    set_config(16'd5, 27'd1, '0, MAX_TOP);
    send_sample(21'd9100, 16'd2);
    send_sample(21'd8800, 16'd4);
    set_config(ades_pkg::RST_PERIOD, FREQ_TOP, '0, '0);
    send_sample(21'd9100, 16'd5);
    set_config(ades_pkg::RST_PERIOD, FREQ_TOP, DEAD_TOP, MAX_TOP);
    send_sample(21'd9100 + HALF_TURN, 16'd6);
    send_sample(21'd9105 + HALF_TURN, 16'd7);
  endtask

  task automatic random_phase(input logic [PW-1:0] period, input logic [FW-1:0] freq,
                              input logic [DW-1:0] dead, input logic [MW-1:0] lim,
                              input int n);
    set_config(period, freq, dead, lim);
    send_random_samples(n);
  endtask

  task automatic test_random_settings();
    random_phase(ades_pkg::RST_PERIOD, ades_pkg::RST_FREQUENCY, ades_pkg::RST_MIN_DELTA,
                 ades_pkg::RST_MAX_SPEED, 250);
    random_phase(16'd1, 27'd1, '0, '0, 100);
    random_phase(ades_pkg::RST_PERIOD, FREQ_TOP, DEAD_TOP, MAX_TOP, 80);
    random_phase(16'd999, 27'd1000000, 21'd3, 40'd50000000, 250);
    repeat (3)
      random_phase(PW'($urandom_range(1, 65535)),
                   FW'($urandom_range(1, (1 << FW) - 1)),
                   DW'($urandom_range(0, 64)),
                   {8'($urandom_range(0, 255)), 32'($urandom)}, 100);
  endtask

  task automatic test_output_holdoff();
    set_config(ades_pkg::RST_PERIOD, ades_pkg::RST_FREQUENCY, ades_pkg::RST_MIN_DELTA,
               ades_pkg::RST_MAX_SPEED);
    hold_cycles = 1500;
    burst_left = 40;
    send_random_samples(30);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.angle_sample = '0;
    in_if.timer_count = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = ades_pkg::REG_TIMER_PERIOD;
    cfg_if.data = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_random_settings();
    test_output_holdoff();
    wait_idle();
    $display("covered %0d angle words, %0d speed words, %0d register writes",
             n_samples, n_results, n_writes);
    $display("settings: reset values, register extremes, random values, output hold-off");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
